// ===== hw/rtl/tcprq_pkg.sv =====
// Shared types and codes for the two-class priority ready queue.
package tcprq_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_PICK   = 2'd1;
    localparam logic [1:0] FUNC_CHANGE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOCHG   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Command from controller to datapath.
    typedef struct packed {
        logic load;        // capture input beat
        logic do_insert;   // insert captured item into selected queue
        logic do_pick;     // pop head of selected queue
        logic do_remove;   // remove found entry (first half of change)
        logic do_reins;    // reinsert found task (second half of change)
        logic sel_pinned;  // queue the operation works on
    } tcprq_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic shared_full;
        logic pinned_full;
        logic shared_empty;
        logic pinned_empty;
        logic hit_shared;
        logic hit_pinned;
        logic same_prio;
    } tcprq_stat_t;

endpackage

// ===== hw/rtl/tcprq_queue.sv =====
// One priority-sorted queue held in a shift-register array with per-entry valid bits.
module tcprq_queue #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         insert,
    input  logic                         ties_after,
    input  logic                         remove,
    input  logic [$clog2(DEPTH)-1:0]     remove_pos,
    input  logic [ID_BITS-1:0]           new_id,
    input  logic [PRIO_BITS-1:0]         new_prio,
    input  logic [ID_BITS-1:0]           find_id,
    output logic                         full,
    output logic                         empty,
    output logic [ID_BITS-1:0]           head_id,
    output logic                         hit,
    output logic [$clog2(DEPTH)-1:0]     hit_pos,
    output logic [PRIO_BITS-1:0]         hit_prio
);
    localparam int PW = $clog2(DEPTH);

    logic [ID_BITS-1:0]   ids_reg   [DEPTH];
    logic [PRIO_BITS-1:0] prios_reg [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     goes_before;
    logic [DEPTH-1:0]     match;

    assign full    = vld_reg[DEPTH-1];
    assign empty   = ~vld_reg[0];
    assign head_id = ids_reg[0];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            goes_before[i] = ~vld_reg[i] ||
                (ties_after ? (prios_reg[i] < new_prio) : (prios_reg[i] <= new_prio));
            match[i] = vld_reg[i] && (ids_reg[i] == find_id);
        end
    end

    // Priority encoder: first matching entry from the head.
    always_comb
    begin
        hit      = 1'b0;
        hit_pos  = '0;
        hit_prio = prios_reg[0];
        for (int i = DEPTH-1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit      = 1'b1;
                hit_pos  = PW'(i);
                hit_prio = prios_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (insert && !full)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], 1'b1};
        end
        else if (remove)
        begin
            vld_reg <= {1'b0, vld_reg[DEPTH-1:1]};
        end
    end

    // Insert: sorted order means goes_before is monotone; shift the tail down.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (insert && !full)
            begin
                if (goes_before[i])
                begin
                    if (i == 0 || !goes_before[(i == 0) ? 0 : i-1])
                    begin
                        ids_reg[i]   <= new_id;
                        prios_reg[i] <= new_prio;
                    end
                    else
                    begin
                        ids_reg[i]   <= ids_reg[(i == 0) ? 0 : i-1];
                        prios_reg[i] <= prios_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
            else if (remove)
            begin
                if (PW'(i) >= remove_pos && i < DEPTH-1)
                begin
                    ids_reg[i]   <= ids_reg[(i < DEPTH-1) ? i+1 : i];
                    prios_reg[i] <= prios_reg[(i < DEPTH-1) ? i+1 : i];
                end
            end
        end
    end
endmodule

// ===== hw/rtl/tcprq_datapath.sv =====
// Datapath: input capture and both queues.
module tcprq_datapath #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int PRIO_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcprq_pkg::tcprq_cmd_t    cmd,
    input  logic [7:0]               task_id,
    input  logic [7:0]               priority_req,
    output tcprq_pkg::tcprq_stat_t   stat,
    output logic [7:0]               head_id
);
    import tcprq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [ID_BITS-1:0]   sh_head, pn_head;
    logic                 sh_hit, pn_hit;
    logic [PW-1:0]        sh_pos, pn_pos;
    logic [PRIO_BITS-1:0] sh_prio, pn_prio;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= task_id[ID_BITS-1:0];
            prio_reg <= priority_req[PRIO_BITS-1:0];
        end
    end

    tcprq_queue #(.DEPTH(DEPTH), .ID_BITS(ID_BITS), .PRIO_BITS(PRIO_BITS)) u_shared (
        .clk, .rst_n,
        .insert     ((cmd.do_insert || cmd.do_reins) && !cmd.sel_pinned),
        .ties_after (1'b0),
        .remove     ((cmd.do_pick || cmd.do_remove) && !cmd.sel_pinned),
        .remove_pos (cmd.do_pick ? PW'(0) : sh_pos),
        .new_id     (id_reg),
        .new_prio   (prio_reg),
        .find_id    (id_reg),
        .full       (stat.shared_full),
        .empty      (stat.shared_empty),
        .head_id    (sh_head),
        .hit        (sh_hit),
        .hit_pos    (sh_pos),
        .hit_prio   (sh_prio)
    );

    tcprq_queue #(.DEPTH(DEPTH), .ID_BITS(ID_BITS), .PRIO_BITS(PRIO_BITS)) u_pinned (
        .clk, .rst_n,
        .insert     ((cmd.do_insert || cmd.do_reins) && cmd.sel_pinned),
        .ties_after (1'b1),
        .remove     ((cmd.do_pick || cmd.do_remove) && cmd.sel_pinned),
        .remove_pos (cmd.do_pick ? PW'(0) : pn_pos),
        .new_id     (id_reg),
        .new_prio   (prio_reg),
        .find_id    (id_reg),
        .full       (stat.pinned_full),
        .empty      (stat.pinned_empty),
        .head_id    (pn_head),
        .hit        (pn_hit),
        .hit_pos    (pn_pos),
        .hit_prio   (pn_prio)
    );

    assign stat.hit_shared = sh_hit;
    assign stat.hit_pinned = pn_hit;
    assign stat.same_prio  = sh_hit ? (sh_prio == prio_reg) : (pn_prio == prio_reg);
    assign head_id = 8'(stat.shared_empty ? pn_head : sh_head);
endmodule

// ===== hw/rtl/tcprq_ctrl.sv =====
// Controller: sequences each beat and holds the result register.
module tcprq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic                     pinned,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tcprq_pkg::tcprq_cmd_t    cmd,
    input  tcprq_pkg::tcprq_stat_t   stat,
    input  logic [7:0]               head_id,
    output logic                     picked_valid,
    output logic [7:0]               picked_id,
    output logic                     picked_from_pinned,
    output logic [1:0]               status,
    output logic                     any_ready
);
    import tcprq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_REIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] func_reg;
    logic       pin_reg;
    logic       out_valid_reg;
    logic       busy_done;
    logic       hit_any;

    assign hit_any  = stat.hit_shared || stat.hit_pinned;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign any_ready = !stat.shared_empty || !stat.pinned_empty;

    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == S_IDLE) && in_valid && !in_stall;
        state_next = state_reg;
        busy_done  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                busy_done = 1'b1;
                state_next = S_IDLE;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        cmd.do_insert  = 1'b1;
                        cmd.sel_pinned = pin_reg;
                    end
                    FUNC_PICK:
                    begin
                        cmd.do_pick    = 1'b1;
                        cmd.sel_pinned = stat.shared_empty;
                    end
                    FUNC_CHANGE:
                    begin
                        cmd.sel_pinned = !stat.hit_shared;
                        if (hit_any && !stat.same_prio)
                        begin
                            cmd.do_remove = 1'b1;
                            busy_done     = 1'b0;
                            state_next    = S_REIN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_REIN:
            begin
                cmd.do_reins   = 1'b1;
                cmd.sel_pinned = pin_reg;
                busy_done      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (busy_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pin_reg  <= pinned;
        end
        else if (state_reg == S_EXEC)
        begin
            pin_reg <= !stat.hit_shared;
        end
        if (state_reg == S_EXEC)
        begin
            picked_valid       <= 1'b0;
            picked_id          <= '0;
            picked_from_pinned <= 1'b0;
            status             <= ST_NOCHG;
            case (func_reg)
                FUNC_INSERT:
                begin
                    status <= (pin_reg ? stat.pinned_full : stat.shared_full) ? ST_FULL
                                                                              : ST_DONE;
                end
                FUNC_PICK:
                begin
                    if (stat.shared_empty && stat.pinned_empty)
                    begin
                        status <= ST_EMPTY;
                    end
                    else
                    begin
                        picked_valid       <= 1'b1;
                        picked_id          <= head_id;
                        picked_from_pinned <= stat.shared_empty;
                        status             <= ST_DONE;
                    end
                end
                FUNC_CHANGE:
                begin
                    status <= (hit_any && !stat.same_prio) ? ST_DONE : ST_NOCHG;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/two_class_priority_ready_queue_top.sv =====
// Top level of the two-class priority ready queue.
// Holds a shared queue (equal priorities last in, first out) and a pinned queue (equal
// priorities first in, first out), each QUEUE_DEPTH entries kept sorted in shift registers.
// A beat is captured in S_IDLE and run in S_EXEC; a priority change that moves a task also
// runs S_REIN (remove, then reinsert); a beat is taken only while the block is idle and the
// result register is free. any_ready reflects the queues at the time the result is read.
module two_class_priority_ready_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] task_id,
    input  logic [7:0] priority_req,
    input  logic       pinned,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       picked_valid,
    output logic [7:0] picked_id,
    output logic       picked_from_pinned,
    output logic [1:0] status,
    output logic       any_ready
);
    import tcprq_pkg::*;

    tcprq_cmd_t  cmd;
    tcprq_stat_t stat;
    logic [7:0]  head_id;

    tcprq_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .func, .pinned, .out_valid, .out_stall,
        .cmd, .stat, .head_id, .picked_valid, .picked_id, .picked_from_pinned,
        .status, .any_ready
    );

    tcprq_datapath #(.DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .PRIO_BITS(PRIO_BITS)) u_dp (
        .clk, .rst_n, .cmd, .task_id, .priority_req, .stat, .head_id
    );
endmodule
